### rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the tempo smoother with synced delay time.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Field widths
   localparam int BPM_W    = 16;   // Q9.7 tempo
   localparam int CONF_W   = 8;    // Q0.8 confidence
   localparam int ALPHA_W  = 16;   // Q0.16 weight
   localparam int SUBDIV_W = 3;
   localparam int DELAY_W  = 16;   // Q11.5 ms
   localparam int TEMPO_W  = 24;   // Q9.15 internal tempo
   localparam int NUM_W    = 37;   // delay dividend
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Serial steps of the multiplier and of the divider
   localparam int SERIAL_STEPS = 16;
   localparam int STEP_CNT_W   = $clog2(SERIAL_STEPS);

   // Tempo constants
   localparam logic [TEMPO_W-1:0] TEMPO_RESET = 24'd3932160;  // 120 BPM
   localparam logic [DELAY_W-1:0] DELAY_MAX   = 16'd47680;    // 1490 ms

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_CONF = 2'd0,
      CSR_ALPHA    = 2'd1,
      CSR_SUBDIV   = 2'd2
   } csr_idx_type;

   // Note value codes
   typedef enum logic [SUBDIV_W-1:0] {
      SUB_HALF      = 3'd0,
      SUB_QUARTER   = 3'd1,
      SUB_DOT_EIGHT = 3'd2,
      SUB_EIGHTH    = 3'd3,
      SUB_SIXTEENTH = 3'd4
   } subdiv_type;

   // Result of the moving average unit
   typedef struct packed {
      logic               done;
      logic [TEMPO_W-1:0] tempo;
   } tss_mul_rsp_type;

   // Result of the delay divider
   typedef struct packed {
      logic               done;
      logic [DELAY_W-1:0] delay;
   } tss_div_rsp_type;

   // 60000 ms * 32 * 32768 * note factor: numerator of the delay division
   function automatic logic [NUM_W-1:0] delay_num(input logic [SUBDIV_W-1:0] code);
      logic [NUM_W-1:0] num;
      unique case (code)
         SUB_HALF:      num = 37'd125829120000;
         SUB_QUARTER:   num = 37'd62914560000;
         SUB_DOT_EIGHT: num = 37'd47185920000;
         SUB_EIGHTH:    num = 37'd31457280000;
         SUB_SIXTEENTH: num = 37'd15728640000;
         default:       num = 37'd62914560000;   // unused codes act as quarter
      endcase
      return num;
   endfunction

endpackage

### rtl/tss_if.sv
// ----------------------------------------------------------------------------
// tss_if
// Channel interfaces: beat reports in, smoothed results out, register writes.
// ----------------------------------------------------------------------------
interface tss_req_if import tss_pkg::*;;
   logic              valid;
   logic              ready;
   logic              report_valid;
   logic [BPM_W-1:0]  report_bpm;
   logic [CONF_W-1:0] report_confidence;

   modport source (output valid, report_valid, report_bpm, report_confidence,
                   input ready);
   modport sink   (input valid, report_valid, report_bpm, report_confidence,
                   output ready);
endinterface

interface tss_rsp_if import tss_pkg::*;;
   logic               valid;
   logic               ready;
   logic [DELAY_W-1:0] delay_time;
   logic [BPM_W-1:0]   smoothed_bpm;
   logic               tempo_known;
   logic               report_accepted;

   modport source (output valid, delay_time, smoothed_bpm, tempo_known,
                   report_accepted, input ready);
   modport sink   (input valid, delay_time, smoothed_bpm, tempo_known,
                   report_accepted, output ready);
endinterface

interface tss_csr_if import tss_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/tss_ema_mul.sv
// ----------------------------------------------------------------------------
// tss_ema_mul
// Moving average update: bit-serial shift-add multiply of (target - old) by
// alpha, one alpha bit per cycle, then rounding, add and clamp.
// ----------------------------------------------------------------------------
module tss_ema_mul import tss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TEMPO_W-1:0]   old_tempo,
   input  logic [TEMPO_W-1:0]   target,
   input  logic [ALPHA_W-1:0]   alpha,
   output tss_mul_rsp_type      rsp
);

   logic                         busy_ff;
   logic                         fin_ff;
   logic                         done_ff;
   logic [STEP_CNT_W-1:0]        cnt_ff;
   logic signed [TEMPO_W:0]      diff_ff;
   logic [ALPHA_W-1:0]           alpha_ff;
   logic signed [TEMPO_W+1:0]    hi_ff;
   logic signed [TEMPO_W+1:0]    hi_in;
   logic [ALPHA_W-1:0]           lo_ff;
   logic [ALPHA_W-1:0]           lo_in;
   logic [TEMPO_W-1:0]           old_ff;
   logic [TEMPO_W-1:0]           res_ff;
   logic [TEMPO_W-1:0]           res_in;
   logic signed [TEMPO_W+1:0]    addend;
   logic signed [TEMPO_W+1:0]    sum;
   logic signed [TEMPO_W+1:0]    step;
   logic signed [TEMPO_W+2:0]    total;

   // Accumulate one partial product, shift the low product bit out
   always_comb begin
      addend = alpha_ff[0] ? {diff_ff[TEMPO_W], diff_ff} : '0;
      sum    = hi_ff + addend;
      hi_in  = sum >>> 1;
      lo_in  = {sum[0], lo_ff[ALPHA_W-1:1]};
   end

   // Round half up, add to old tempo, clamp to the tempo range
   always_comb begin
      step  = hi_ff + {{(TEMPO_W+1){1'b0}}, lo_ff[ALPHA_W-1]};
      total = {3'b000, old_ff} + {step[TEMPO_W+1], step};
      if (total[TEMPO_W+2]) begin
         res_in = '0;
      end else if (total[TEMPO_W+1:TEMPO_W] != 2'b00) begin
         res_in = '1;
      end else begin
         res_in = total[TEMPO_W-1:0];
      end
   end

   // Sequence the serial steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            cnt_ff   <= STEP_CNT_W'(SERIAL_STEPS - 1);
            hi_ff    <= '0;
            lo_ff    <= '0;
            diff_ff  <= $signed({1'b0, target}) - $signed({1'b0, old_tempo});
            alpha_ff <= alpha;
            old_ff   <= old_tempo;
         end else if (busy_ff) begin
            hi_ff    <= hi_in;
            lo_ff    <= lo_in;
            alpha_ff <= alpha_ff >> 1;
            cnt_ff   <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            res_ff  <= res_in;
            done_ff <= 1'b1;
         end
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.tempo = res_ff;

endmodule

### rtl/tss_delay_div.sv
// ----------------------------------------------------------------------------
// tss_delay_div
// Delay time: restoring division of the note numerator by the tempo, one
// quotient bit per cycle, with rounding, saturation and the zero cases.
// ----------------------------------------------------------------------------
module tss_delay_div import tss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 have_tempo,
   input  logic [TEMPO_W-1:0]   tempo,
   input  logic [SUBDIV_W-1:0]  subdivision,
   output tss_div_rsp_type      rsp
);

   localparam int HI_W = NUM_W - SERIAL_STEPS;

   typedef enum logic [2:0] {
      D_IDLE,
      D_PREP,
      D_LOAD,
      D_ITER,
      D_FIN
   } div_state_type;

   div_state_type          state_ff;
   logic                   done_ff;
   logic                   zero_ff;
   logic                   ovf_ff;
   logic [STEP_CNT_W-1:0]  cnt_ff;
   logic [TEMPO_W-1:0]     tempo_ff;
   logic [NUM_W-1:0]       num_ff;
   logic [NUM_W-1:0]       dvd_ff;
   logic [NUM_W-1:0]       dvd_in;
   logic [TEMPO_W-1:0]     rem_ff;
   logic [TEMPO_W-1:0]     rem_in;
   logic [SERIAL_STEPS-1:0] low_ff;
   logic [SERIAL_STEPS-1:0] quo_ff;
   logic [SERIAL_STEPS-1:0] quo_in;
   logic [DELAY_W-1:0]     delay_ff;
   logic [TEMPO_W:0]       rem_sh;
   logic                   fits;
   logic                   ovf_in;

   // Dividend with half the divisor added for round to nearest
   assign dvd_in = num_ff + {{(NUM_W-TEMPO_W+1){1'b0}}, tempo_ff[TEMPO_W-1:1]};

   // Quotient exceeds 16 bits when the top part is not below the divisor
   assign ovf_in = {{(TEMPO_W-HI_W){1'b0}}, dvd_ff[NUM_W-1:SERIAL_STEPS]} >= tempo_ff;

   // One restoring step
   always_comb begin
      rem_sh = {rem_ff, low_ff[SERIAL_STEPS-1]};
      fits   = rem_sh >= {1'b0, tempo_ff};
      rem_in = fits ? TEMPO_W'(rem_sh - {1'b0, tempo_ff}) : rem_sh[TEMPO_W-1:0];
      quo_in = {quo_ff[SERIAL_STEPS-2:0], fits};
   end

   // Sequence prepare, load, iterate and finish
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  tempo_ff <= tempo;
                  num_ff   <= delay_num(subdivision);
                  zero_ff  <= !have_tempo || (tempo[TEMPO_W-1:15] == '0);
                  state_ff <= D_PREP;
               end
            end
            D_PREP: begin
               dvd_ff   <= dvd_in;
               state_ff <= D_LOAD;
            end
            D_LOAD: begin
               ovf_ff <= ovf_in;
               rem_ff <= {{(TEMPO_W-HI_W){1'b0}}, dvd_ff[NUM_W-1:SERIAL_STEPS]};
               low_ff <= dvd_ff[SERIAL_STEPS-1:0];
               cnt_ff <= STEP_CNT_W'(SERIAL_STEPS - 1);
               // skip the division when the result is fixed
               if (zero_ff || ovf_in) begin
                  state_ff <= D_FIN;
               end else begin
                  state_ff <= D_ITER;
               end
            end
            D_ITER: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               low_ff <= low_ff << 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               priority if (zero_ff) begin
                  delay_ff <= '0;
               end else if (ovf_ff || quo_ff > DELAY_MAX) begin
                  delay_ff <= DELAY_MAX;
               end else begin
                  delay_ff <= quo_ff;
               end
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.delay = delay_ff;

endmodule

### rtl/tempo_smoother_delay_sync.sv
// ----------------------------------------------------------------------------
// tempo_smoother_delay_sync
// Beat report gate, moving average tempo smoother and note-synced delay time.
// ----------------------------------------------------------------------------
// Each report transaction gives one result transaction. A report that passes
// the validity and confidence gate loads the tempo (first one) or moves it by
// the moving average; the result carries the smoothed tempo and the delay for
// the selected note value. One item is in work at a time: a report that
// updates an existing tempo passes the 16-step bit-serial multiplier of the
// moving average and then the 16-step restoring divider of the delay time,
// any other report the divider only; the divider skips its steps when the
// tempo is unknown, below 1 BPM, or the quotient does not fit in 16 bits.
// A finished result waits in an output register, so the next report is
// taken while it is still pending.
// Register writes are always ready and take effect at once; writes to an
// index past the last register are dropped.
// ----------------------------------------------------------------------------
module tempo_smoother_delay_sync import tss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   tss_req_if.sink       req_bus,
   tss_rsp_if.source     rsp_bus,
   tss_csr_if.sink       csr_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMA,
      ST_DELAY,
      ST_HOLD
   } state_type;

   state_type              state_ff;
   logic [CONF_W-1:0]      min_conf_ff;
   logic [ALPHA_W-1:0]     alpha_ff;
   logic [SUBDIV_W-1:0]    subdiv_ff;
   logic [TEMPO_W-1:0]     tempo_ff;
   logic                   have_ff;
   logic [TEMPO_W-1:0]     target_ff;
   logic                   accepted_ff;
   logic                   mul_start_ff;
   logic                   div_start_ff;
   logic                   rsp_valid_ff;
   logic [DELAY_W-1:0]     rsp_delay_ff;
   logic [BPM_W-1:0]       rsp_bpm_ff;
   logic                   rsp_known_ff;
   logic                   rsp_acc_ff;
   logic                   accepted_in;
   logic                   req_take;
   logic                   out_free;
   logic                   rsp_load;
   logic [TEMPO_W:0]       shown_sum;
   logic [BPM_W-1:0]       shown_in;
   tss_mul_rsp_type        mul_rsp;
   tss_div_rsp_type        div_rsp;

   // Gate the report
   assign accepted_in = req_bus.report_valid && (req_bus.report_confidence >= min_conf_ff);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Load the output register once a result is ready and the slot is free
   assign rsp_load = ((state_ff == ST_DELAY && div_rsp.done) || state_ff == ST_HOLD) &&
                     out_free;

   // Round the Q9.15 tempo to Q9.7, saturate
   always_comb begin
      shown_sum = {1'b0, tempo_ff} + (TEMPO_W+1)'(128);
      shown_in  = shown_sum[TEMPO_W] ? '1 : shown_sum[TEMPO_W-1:8];
   end

   // Register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_conf_ff <= 8'd128;
         alpha_ff    <= 16'd6554;
         subdiv_ff   <= SUB_QUARTER;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MIN_CONF: min_conf_ff <= csr_bus.data[CONF_W-1:0];
            CSR_ALPHA:    alpha_ff    <= csr_bus.data[ALPHA_W-1:0];
            CSR_SUBDIV:   subdiv_ff   <= csr_bus.data[SUBDIV_W-1:0];
            default:      ;
         endcase
      end
   end

   // Sequence one report, hold the tempo and the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tempo_ff     <= TEMPO_RESET;
         have_ff      <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_bus.ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  accepted_ff <= accepted_in;
                  target_ff   <= {req_bus.report_bpm, 8'd0};
                  if (accepted_in && have_ff) begin
                     mul_start_ff <= 1'b1;
                     state_ff     <= ST_EMA;
                  end else begin
                     if (accepted_in) begin
                        tempo_ff <= {req_bus.report_bpm, 8'd0};
                        have_ff  <= 1'b1;
                     end
                     div_start_ff <= 1'b1;
                     state_ff     <= ST_DELAY;
                  end
               end
            end
            ST_EMA: begin
               if (mul_rsp.done) begin
                  tempo_ff     <= mul_rsp.tempo;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DELAY;
               end
            end
            ST_DELAY, ST_HOLD: begin
               if (div_rsp.done || state_ff == ST_HOLD) begin
                  if (out_free) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_delay_ff <= div_rsp.delay;
                     rsp_bpm_ff   <= shown_in;
                     rsp_known_ff <= have_ff;
                     rsp_acc_ff   <= accepted_ff;
                     state_ff     <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   tss_ema_mul u_ema_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start_ff),
      .old_tempo (tempo_ff),
      .target    (target_ff),
      .alpha     (alpha_ff),
      .rsp       (mul_rsp)
   );

   tss_delay_div u_delay_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start_ff),
      .have_tempo  (have_ff),
      .tempo       (tempo_ff),
      .subdivision (subdiv_ff),
      .rsp         (div_rsp)
   );

   // Drive the result channel
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.delay_time      = rsp_delay_ff;
   assign rsp_bus.smoothed_bpm    = rsp_bpm_ff;
   assign rsp_bus.tempo_known     = rsp_known_ff;
   assign rsp_bus.report_accepted = rsp_acc_ff;

endmodule
